[hw/rtl/lcg48_pkg.sv]
// types and constants for the 48-bit linear congruential generator core
// no dependencies; used by lcg48_random_generator_core
package lcg48_pkg;

	localparam int unsigned StateW = 48;

	typedef enum logic [1:0] {
		CMD_LOAD     = 2'd0,
		CMD_SEED     = 2'd1,
		CMD_XOR_BYTE = 2'd2,
		CMD_READ     = 2'd3
	} command_t;

	typedef struct packed {
		command_t    command;
		logic [47:0] seed_value;
		logic [7:0]  byte_value;
		logic [2:0]  byte_index;
		logic        advance;
	} in_item_t;

	typedef struct packed {
		logic [47:0] fraction;
		logic [31:0] upper_word;
		logic [30:0] positive_word;
	} out_item_t;

	localparam logic [47:0] RESET_STATE = 48'h1234_abcd_330e;
	localparam logic [15:0] SEED_LOW    = 16'h330e;
	localparam logic [31:0] LCG_MULT_LO = 32'hdeec_e66d;
	localparam logic [2:0]  LCG_MULT_HI = 3'h5;
	localparam logic [47:0] LCG_ADD     = 48'h0000_0000_000b;
	localparam logic [2:0]  NUM_LANES   = 3'd6;

endpackage

[hw/rtl/lcg48_random_generator_core.sv]
// top level of the 48-bit linear congruential generator (drand48 step)
// depends on lcg48_pkg for the item types, command codes and constants
//
// channel   direction  handshake              payload
// -------   ---------  ---------------------  ---------------------------
// in        to core    in_valid / in_stall    in_item  (lcg48_pkg::in_item_t)
// out       from core  out_valid / out_stall  out_item (lcg48_pkg::out_item_t)
// cfg       to core    cfg_we                 cfg_wdata (byte order swap)
//
// one transfer in per cycle unless in_stall is raised, one result per transfer
// input register (s1) -> state update and result register (s2)
// the single-cycle state loop (32x32 multiply plus small cross terms) sets the rate
// reset loads the state with 0x1234abcd330e and clears swap and valid flags
// out_stall holds the result register; s1 still takes one transfer behind it
module lcg48_random_generator_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  lcg48_pkg::in_item_t  in_item,
	output logic                 out_valid,
	input  logic                 out_stall,
	output lcg48_pkg::out_item_t out_item,
	input  logic                 cfg_we,
	input  logic                 cfg_wdata
);

	// configuration
	logic swap_q;

	// stage 1: accepted command waiting for the state update
	logic                s1_valid_s1;
	lcg48_pkg::in_item_t item_s1;

	// generator state and result register
	logic [47:0]          state_q;
	logic                 valid_s2;
	lcg48_pkg::out_item_t result_s2;

	// handshake
	logic s2_free;
	logic s1_move;
	logic in_take;

	// next state logic
	logic [47:0] next_state;
	logic [47:0] step_state;
	logic [47:0] xor_state;
	logic [63:0] prod_lo;
	logic [31:0] prod_hi;
	logic [18:0] prod_mid;
	logic [16:0] cross_sum;
	logic [2:0]  lane;

	// result register is free when empty or being drained this cycle
	assign s2_free  = !valid_s2 || !out_stall;
	assign s1_move  = s1_valid_s1 && s2_free;
	assign in_stall = s1_valid_s1 && !s2_free;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swap_q <= 1'b0;
		end else if (cfg_we) begin
			swap_q <= cfg_wdata;
		end
	end

	// x * 0x5deece66d mod 2^48, split so no product is wider than 32x32
	// cross terms only matter in their low 16 bits since they sit at bit 32
	assign prod_lo   = state_q[31:0] * lcg48_pkg::LCG_MULT_LO;
	assign prod_hi   = state_q[47:32] * lcg48_pkg::LCG_MULT_LO[15:0];
	assign prod_mid  = state_q[15:0] * lcg48_pkg::LCG_MULT_HI;
	assign cross_sum = {1'b0, prod_hi[15:0]} + {1'b0, prod_mid[15:0]};
	assign step_state = prod_lo[47:0] + {cross_sum[15:0], 32'h0000_0000}
		+ lcg48_pkg::LCG_ADD;

	// byte lane, flipped in its low bit when byte order swap is set
	assign lane = item_s1.byte_index ^ {2'b00, swap_q};

	always_comb begin
		xor_state = state_q;
		for (int i = 0; i < 6; i++) begin
			if (lane == 3'(i)) begin
				xor_state[i*8 +: 8] = state_q[i*8 +: 8] ^ item_s1.byte_value;
			end
		end
	end

	always_comb begin
		unique case (item_s1.command)
			lcg48_pkg::CMD_LOAD: begin
				next_state = item_s1.seed_value;
			end
			lcg48_pkg::CMD_SEED: begin
				next_state = {item_s1.seed_value[31:0], lcg48_pkg::SEED_LOW};
			end
			lcg48_pkg::CMD_XOR_BYTE: begin
				// lanes six and seven leave the state as it is
				next_state = xor_state;
			end
			lcg48_pkg::CMD_READ: begin
				next_state = item_s1.advance ? step_state : state_q;
			end
			default: begin
				next_state = state_q;
			end
		endcase
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (in_take) begin
			s1_valid_s1 <= 1'b1;
		end else if (s1_move) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1 <= in_item;
		end
	end

	// state and result control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= lcg48_pkg::RESET_STATE;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_move) begin
				state_q <= next_state;
			end
			if (s1_move) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			result_s2.fraction      <= next_state;
			result_s2.upper_word    <= next_state[47:16];
			result_s2.positive_word <= next_state[47:17];
		end
	end

	assign out_valid = valid_s2;
	assign out_item  = result_s2;

`ifndef SYNTHESIS
	// a finished command shows up as the new state in the result register
	a_result_is_state: assert property (@(posedge clk) disable iff (!arst_n)
		s1_move |=> (out_valid && out_item.fraction == state_q))
		else $error("result does not match generator state");

	// input is only held off while stage 1 is occupied
	a_stall_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> s1_valid_s1)
		else $error("input stalled with stage 1 empty");

	// the state only changes when a command completes
	a_state_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_move |=> $stable(state_q))
		else $error("state changed without a command");

	// a peek leaves the state untouched
	a_peek_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_move && item_s1.command == lcg48_pkg::CMD_READ && !item_s1.advance)
		|=> $stable(state_q))
		else $error("peek changed the state");
`endif

endmodule
